@@ sv/tgf_pkg.sv @@
`timescale 1ns / 1ps
// tgf_pkg: shared types, codes and defaults for the team queue.
// No dependencies; used by the interfaces, the output stage and the top level.
package tgf_pkg;

    // default sizes
    localparam int unsigned PERSONS_DEF = 1024;
    localparam int unsigned TEAMS_DEF   = 256;
    localparam int unsigned POOL_DEF    = 1024;

    // word field widths
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned PERSON_W = 10;
    localparam int unsigned TEAM_W   = 8;
    localparam int unsigned STATUS_W = 2;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        K_ASSIGN = 2'd0,
        K_ENQ    = 2'd1,
        K_DEQ    = 2'd2
    } t_kind;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [PERSON_W-1:0] person_out;
        t_status             status;
    } t_result;

    // Reduce a 10-bit value modulo a constant: compare-subtract ladder,
    // one step per power of two of the modulus that still fits.
    function automatic logic [PERSON_W-1:0] reduce(input logic [PERSON_W-1:0] v,
                                                   input int unsigned m);
        logic [31:0] r;
        logic [31:0] s;
        r = 32'(v);
        for (int k = PERSON_W - 1; k >= 0; k--) begin
            s = 32'(m) << k;
            if ((s < (32'd1 << PERSON_W)) && (r >= s)) begin
                r = r - s;
            end
        end
        return r[PERSON_W-1:0];
    endfunction

endpackage

@@ sv/tgf_if.sv @@
`timescale 1ns / 1ps
// tgf_in_if / tgf_out_if: valid/ready channels of the team queue.
// Depends on tgf_pkg for the field widths.
interface tgf_in_if;
    logic                          valid;
    logic                          ready;
    logic [tgf_pkg::KIND_W-1:0]    kind;
    logic [tgf_pkg::PERSON_W-1:0]  person_id;
    logic [tgf_pkg::TEAM_W-1:0]    team_id;

    modport source(output valid, kind, person_id, team_id, input ready);
    modport sink(input valid, kind, person_id, team_id, output ready);
endinterface

interface tgf_out_if;
    logic                          valid;
    logic                          ready;
    logic [tgf_pkg::PERSON_W-1:0]  person_out;
    logic [tgf_pkg::STATUS_W-1:0]  status;

    modport source(output valid, person_out, status, input ready);
    modport sink(input valid, person_out, status, output ready);
endinterface

@@ sv/tgf_ram.sv @@
`timescale 1ns / 1ps
// tgf_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module tgf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tgf_out.sv @@
`timescale 1ns / 1ps
// tgf_out: output register of the team queue, fed from a one-word pending slot.
// Depends on tgf_pkg and tgf_out_if.
module tgf_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pend_v,
    input  tgf_pkg::t_result i_pend,
    output logic             o_take,
    tgf_out_if.source        o_out
);

    logic             r_valid;
    tgf_pkg::t_result r_data;

    // pending word moves whenever the register is empty or being drained
    assign o_take = i_pend_v && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_out.ready) begin
            r_valid <= i_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_data <= i_pend;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.person_out = r_data.person_out;
    assign o_out.status     = r_data.status;

endmodule

@@ sv/team_grouped_fifo.sv @@
`timescale 1ns / 1ps
// team_grouped_fifo: team queue built on five synchronous registered-read RAMs.
// Depends on tgf_pkg, tgf_if, tgf_ram and tgf_out.
//
// Usage:
//   i_in carries one command word: kind 0 assigns person_id to team_id,
//   kind 1 enqueues person_id behind its team, kind 2 dequeues the front
//   person. o_out returns one word per command: person_out (dequeued
//   person, else 0) and status (0 ok, 1 dequeue on empty, 2 node pool full).
//   Out-of-range person and team numbers wrap modulo PERSONS and TEAMS.
// Timing:
//   Assign, unused kinds and dequeue on empty finish in the accept cycle.
//   Enqueue reads the map and free link, then the team entry, then writes
//   back pointers; dequeue reads the team entry, then the node entry, then
//   writes back pointers (the RAMs read registered). A result moves from the
//   pending slot to the output register, and the next command enters then.
// Reset:
//   After reset the membership map and team in-line flags are swept to zero,
//   one entry per cycle up to max(PERSONS, TEAMS); i_in.ready stays low
//   meanwhile. All queue state returns empty.
// Stall:
//   One finished word waits in a pending slot while o_out holds another; a
//   further command is held off only until the pending word moves on.
module team_grouped_fifo #(
    parameter int unsigned PERSONS    = tgf_pkg::PERSONS_DEF,
    parameter int unsigned TEAMS      = tgf_pkg::TEAMS_DEF,
    parameter int unsigned POOL_NODES = tgf_pkg::POOL_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tgf_in_if.sink     i_in,
    tgf_out_if.source  o_out
);

    localparam int unsigned PW    = $clog2(PERSONS);
    localparam int unsigned TW    = $clog2(TEAMS);
    localparam int unsigned NW    = $clog2(POOL_NODES);
    localparam int unsigned FW    = $clog2(POOL_NODES + 1);
    localparam int unsigned CLR_N = (PERSONS > TEAMS) ? PERSONS : TEAMS;
    localparam int unsigned CW    = $clog2(CLR_N);
    localparam int unsigned SW    = 2 * NW + 1;   // {in_line, head, tail}

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ENQ1,
        S_ENQ2,
        S_DEQ1,
        S_DEQ2
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_clr;
    logic [PW-1:0]    r_p;
    logic [TW-1:0]    r_tm;
    logic [NW-1:0]    r_node;
    logic [SW-1:0]    r_ts;
    logic [TW-1:0]    r_tlink;
    logic [FW-1:0]    r_fresh;
    logic [NW-1:0]    r_free_head;
    logic             r_free_ne;
    logic [TW-1:0]    r_line_head;
    logic [TW-1:0]    r_line_tail;
    logic             r_line_ne;
    logic             r_pend_v;
    tgf_pkg::t_result r_pend;

    // RAM ports
    logic          map_we;
    logic [PW-1:0] map_waddr, map_raddr;
    logic [TW-1:0] map_wdata, map_rd;
    logic          np_we;
    logic [NW-1:0] np_waddr, np_raddr;
    logic [PW-1:0] np_wdata, np_rd;
    logic          nl_we;
    logic [NW-1:0] nl_waddr, nl_raddr;
    logic [NW-1:0] nl_wdata, nl_rd;
    logic          ts_we;
    logic [TW-1:0] ts_waddr, ts_raddr;
    logic [SW-1:0] ts_wdata, ts_rd;
    logic          tl_we;
    logic [TW-1:0] tl_waddr, tl_raddr;
    logic [TW-1:0] tl_wdata, tl_rd;

    logic [tgf_pkg::PERSON_W-1:0] p_mod, t_mod;
    logic [PW-1:0] p_red;
    logic [TW-1:0] t_red;
    logic          in_fire;
    logic          take;
    logic          grab_ok;
    logic [NW-1:0] grab_n;
    logic          ts_in_line;
    logic [NW-1:0] ts_head, ts_tail;
    logic [NW-1:0] r_ts_head, r_ts_tail;

    // input reduction
    always_comb begin
        p_mod = tgf_pkg::reduce(i_in.person_id, PERSONS);
        t_mod = tgf_pkg::reduce(tgf_pkg::PERSON_W'(i_in.team_id), TEAMS);
        p_red = PW'(p_mod);
        t_red = TW'(t_mod);
    end

    assign i_in.ready = (r_state == S_IDLE) && (!r_pend_v || take);
    assign in_fire    = i_in.valid && i_in.ready;

    assign ts_in_line = ts_rd[2*NW];
    assign ts_head    = ts_rd[2*NW-1:NW];
    assign ts_tail    = ts_rd[NW-1:0];
    assign r_ts_head  = r_ts[2*NW-1:NW];
    assign r_ts_tail  = r_ts[NW-1:0];

    // node grab: free stack first, then never-used nodes
    always_comb begin
        grab_ok = 1'b0;
        grab_n  = r_free_head;
        if (r_free_ne) begin
            grab_ok = 1'b1;
        end else if (r_fresh < FW'(POOL_NODES)) begin
            grab_ok = 1'b1;
            grab_n  = r_fresh[NW-1:0];
        end
    end

    // RAM address and write control
    always_comb begin
        map_we    = 1'b0;
        map_waddr = p_red;
        map_wdata = t_red;
        map_raddr = p_red;
        np_we     = 1'b0;
        np_waddr  = grab_n;
        np_wdata  = r_p;
        np_raddr  = ts_head;
        nl_we     = 1'b0;
        nl_waddr  = ts_tail;
        nl_wdata  = r_node;
        nl_raddr  = r_free_head;
        ts_we     = 1'b0;
        ts_waddr  = r_tm;
        ts_wdata  = '0;
        ts_raddr  = r_line_head;
        tl_we     = 1'b0;
        tl_waddr  = r_line_tail;
        tl_wdata  = r_tm;
        tl_raddr  = r_line_head;
        case (r_state)
            S_CLEAR: begin
                map_we    = (32'(r_clr) < 32'(PERSONS));
                map_waddr = PW'(r_clr);
                map_wdata = '0;
                ts_we     = (32'(r_clr) < 32'(TEAMS));
                ts_waddr  = TW'(r_clr);
                ts_wdata  = '0;
            end
            S_IDLE: begin
                map_we = in_fire && (i_in.kind == tgf_pkg::K_ASSIGN);
            end
            S_ENQ1: begin
                np_we    = grab_ok;
                ts_raddr = map_rd;
            end
            S_ENQ2: begin
                ts_we = 1'b1;
                if (ts_in_line) begin
                    nl_we    = 1'b1;
                    ts_wdata = {1'b1, ts_head, r_node};
                end else begin
                    ts_wdata = {1'b1, r_node, r_node};
                    tl_we    = r_line_ne;
                end
            end
            S_DEQ1: begin
                nl_raddr = ts_head;
            end
            S_DEQ2: begin
                ts_we    = 1'b1;
                ts_wdata = (r_node == r_ts_tail) ? {1'b0, r_ts_head, r_ts_tail}
                                                 : {1'b1, nl_rd, r_ts_tail};
                nl_we    = 1'b1;
                nl_waddr = r_node;
                nl_wdata = r_free_ne ? r_free_head : r_node;
            end
            default: begin
            end
        endcase
    end

    // sequencer, pool and line registers, pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_fresh     <= '0;
            r_free_head <= '0;
            r_free_ne   <= 1'b0;
            r_line_head <= '0;
            r_line_tail <= '0;
            r_line_ne   <= 1'b0;
            r_pend_v    <= 1'b0;
        end else begin
            if (take) begin
                r_pend_v <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CW'(CLR_N - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_p <= p_red;
                        case (i_in.kind)
                            tgf_pkg::K_ENQ: begin
                                r_state <= S_ENQ1;
                            end
                            tgf_pkg::K_DEQ: begin
                                if (r_line_ne) begin
                                    r_state <= S_DEQ1;
                                end else begin
                                    r_pend_v <= 1'b1;
                                    r_pend   <= '{person_out: '0,
                                                  status: tgf_pkg::ST_EMPTY};
                                end
                            end
                            default: begin
                                r_pend_v <= 1'b1;
                                r_pend   <= '{person_out: '0, status: tgf_pkg::ST_OK};
                            end
                        endcase
                    end
                end
                S_ENQ1: begin
                    r_tm   <= map_rd;
                    r_node <= grab_n;
                    if (!grab_ok) begin
                        r_state  <= S_IDLE;
                        r_pend_v <= 1'b1;
                        r_pend   <= '{person_out: '0, status: tgf_pkg::ST_FULL};
                    end else begin
                        r_state <= S_ENQ2;
                        if (r_free_ne) begin
                            if (nl_rd == r_free_head) begin
                                r_free_ne <= 1'b0;
                            end else begin
                                r_free_head <= nl_rd;
                            end
                        end else begin
                            r_fresh <= r_fresh + 1'b1;
                        end
                    end
                end
                S_ENQ2: begin
                    if (!ts_in_line) begin
                        r_line_tail <= r_tm;
                        if (!r_line_ne) begin
                            r_line_head <= r_tm;
                            r_line_ne   <= 1'b1;
                        end
                    end
                    r_state  <= S_IDLE;
                    r_pend_v <= 1'b1;
                    r_pend   <= '{person_out: '0, status: tgf_pkg::ST_OK};
                end
                S_DEQ1: begin
                    r_tm    <= r_line_head;
                    r_node  <= ts_head;
                    r_ts    <= ts_rd;
                    r_tlink <= tl_rd;
                    r_state <= S_DEQ2;
                end
                S_DEQ2: begin
                    if (r_node == r_ts_tail) begin
                        if (r_tm == r_line_tail) begin
                            r_line_ne <= 1'b0;
                        end else begin
                            r_line_head <= r_tlink;
                        end
                    end
                    r_free_head <= r_node;
                    r_free_ne   <= 1'b1;
                    r_state     <= S_IDLE;
                    r_pend_v    <= 1'b1;
                    r_pend      <= '{person_out: tgf_pkg::PERSON_W'(np_rd),
                                     status: tgf_pkg::ST_OK};
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // memories
    tgf_ram #(.WIDTH(TW), .DEPTH(PERSONS)) u_team_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(map_wdata),
        .i_raddr(map_raddr), .o_rdata(map_rd)
    );

    tgf_ram #(.WIDTH(PW), .DEPTH(POOL_NODES)) u_node_person (
        .i_clk(i_clk), .i_we(np_we), .i_waddr(np_waddr), .i_wdata(np_wdata),
        .i_raddr(np_raddr), .o_rdata(np_rd)
    );

    tgf_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_node_link (
        .i_clk(i_clk), .i_we(nl_we), .i_waddr(nl_waddr), .i_wdata(nl_wdata),
        .i_raddr(nl_raddr), .o_rdata(nl_rd)
    );

    tgf_ram #(.WIDTH(SW), .DEPTH(TEAMS)) u_team_state (
        .i_clk(i_clk), .i_we(ts_we), .i_waddr(ts_waddr), .i_wdata(ts_wdata),
        .i_raddr(ts_raddr), .o_rdata(ts_rd)
    );

    tgf_ram #(.WIDTH(TW), .DEPTH(TEAMS)) u_team_link (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(tl_waddr), .i_wdata(tl_wdata),
        .i_raddr(tl_raddr), .o_rdata(tl_rd)
    );

    // output register
    tgf_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pend_v(r_pend_v),
        .i_pend  (r_pend),
        .o_take  (take),
        .o_out   (o_out)
    );

    // fresh-node counter never passes the pool size
    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= FW'(POOL_NODES))
        else $error("fresh node count beyond pool");

    // a command finishing its writes never meets an occupied pending slot
    a_pend_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENQ2 || r_state == S_DEQ2 || r_state == S_ENQ1) |-> !r_pend_v)
        else $error("pending slot busy at command end");

    // a dequeue in progress always works on a non-empty line
    a_deq_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEQ1 || r_state == S_DEQ2) |-> r_line_ne)
        else $error("dequeue on empty line");

    // the clearing pass ends straight into idle with the line and free stack empty
    a_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_clr == CW'(CLR_N - 1)) |=>
            (r_state == S_IDLE && !r_line_ne && !r_free_ne))
        else $error("clearing pass exit");

endmodule
